### rtl/gfne_pkg.sv
// Shared types, constants and direction tables for the grid neighbour expansion block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package gfne_pkg;

  // Size of the occupancy store.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // The coordinate fields are eight bits wide, so the usable grid never exceeds 256.
  localparam logic [8:0] EFF_W_MAX = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
  localparam logic [8:0] EFF_H_MAX = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic       is_query;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] occupancy;
  } cmd_t;

  typedef struct packed {
    logic [8:0] grid_width;
    logic [8:0] grid_height;
    logic [7:0] free_threshold;
  } cfg_t;

  // Direction order: west, north, east, south, NW, SE, SW, NE.
  // Offsets are two-bit two's complement values.
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0: r = 2'b11;
      3'd1: r = 2'b00;
      3'd2: r = 2'b01;
      3'd3: r = 2'b00;
      3'd4: r = 2'b11;
      3'd5: r = 2'b01;
      3'd6: r = 2'b11;
      3'd7: r = 2'b01;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0: r = 2'b00;
      3'd1: r = 2'b11;
      3'd2: r = 2'b00;
      3'd3: r = 2'b01;
      3'd4: r = 2'b11;
      3'd5: r = 2'b01;
      3'd6: r = 2'b01;
      3'd7: r = 2'b11;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gfne_intf.sv
// Channel interfaces of the block: input items, result items and configuration writes.
// Depends on gfne_pkg for the configuration port widths.
`default_nettype none

interface gfne_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic [7:0] occupancy;

  modport source (output valid, kind, cell_x, cell_y, occupancy, input ready);
  modport sink   (input valid, kind, cell_x, cell_y, occupancy, output ready);
endinterface

interface gfne_result_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] neighbour_x;
  logic [7:0] neighbour_y;
  logic       last;

  modport source (output valid, found, neighbour_x, neighbour_y, last, input ready);
  modport sink   (input valid, found, neighbour_x, neighbour_y, last, output ready);
endinterface

interface gfne_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gfne_pkg::CFG_IDX_W-1:0]   index;
  logic [gfne_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/grid_free_neighbour_expansion.sv
// Top level of the grid free-neighbour expansion block: front end, command queue
// and back end. Depends on gfne_pkg, gfne_intf, gfne_front, gfne_queue and gfne_back.
`default_nettype none

// The block keeps an occupancy grid of byte cells in a single-port memory of
// MAX_WIDTH x MAX_HEIGHT entries. A word with kind 0 writes one cell; a write
// whose column or row lies outside the store is dropped. A word with kind 1
// queries a cell: the block returns, in the order west, north, east, south,
// north-west, south-east, south-west, north-east, one result word for every
// neighbour that lies inside the configured width and height and whose occupancy
// is strictly below the threshold, and flags the final one with last. A query
// with no free neighbour returns a single word with found clear and last set.
// Reading a cell that was never written gives an arbitrary value. Input words
// go into a four-entry command queue, so the input side keeps accepting words
// while the back end is busy or the result side stalls, until the queue fills.
// A query walks the eight neighbours in turn, reading the memory through the
// single port for each one inside the configured grid, settles the last read
// and then emits the final result; a stall on the result side holds it up. The
// configuration registers are written through their own port, which is always
// ready, and should be changed only while the block is idle.
module grid_free_neighbour_expansion (
  input  wire logic  clk,
  input  wire logic  rst,
  gfne_item_if.sink     item,
  gfne_result_if.source result,
  gfne_cfg_if.sink      cfg
);
  import gfne_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  cfg_t cfg_regs;
  logic pop;
  cmd_t head;
  logic nonempty;

  // The front end classifies words and holds the registers.
  gfne_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .cfg_regs (cfg_regs)
  );

  // Commands wait here until the back end is free.
  gfne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  // The back end performs writes and neighbour scans against the memory.
  gfne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head),
    .cmd_valid (nonempty),
    .cmd_pop   (pop),
    .cfg_regs  (cfg_regs),
    .result    (result)
  );

endmodule

`default_nettype wire

### rtl/gfne_front.sv
// Front end: accepts input words, classifies them into commands and holds the
// configuration registers. Depends on gfne_pkg and gfne_intf.
`default_nettype none

module gfne_front (
  input  wire logic        clk,
  input  wire logic        rst,
  gfne_item_if.sink        item,
  gfne_cfg_if.sink         cfg,
  input  wire logic        q_full,
  output logic             push,
  output gfne_pkg::cmd_t   push_cmd,
  output gfne_pkg::cfg_t   cfg_regs
);
  import gfne_pkg::*;

  logic in_store;

  assign item.ready = !q_full;
  assign cfg.ready  = 1'b1;

  // Writes that fall outside the store are dropped here and never reach the back.
  assign in_store = (32'(item.cell_x) < MAX_WIDTH) && (32'(item.cell_y) < MAX_HEIGHT);
  assign push     = item.valid && item.ready && ((item.kind == KIND_QUERY) || in_store);

  assign push_cmd.is_query  = (item.kind == KIND_QUERY);
  assign push_cmd.x         = item.cell_x;
  assign push_cmd.y         = item.cell_y;
  assign push_cmd.occupancy = item.occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.grid_width     <= 9'd256;
      cfg_regs.grid_height    <= 9'd256;
      cfg_regs.free_threshold <= 8'd50;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GRID_WIDTH:     cfg_regs.grid_width     <= cfg.data;
        REG_GRID_HEIGHT:    cfg_regs.grid_height    <= cfg.data;
        REG_FREE_THRESHOLD: cfg_regs.free_threshold <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/gfne_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on gfne_pkg for the command type and depth.
`default_nettype none

module gfne_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire gfne_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output gfne_pkg::cmd_t       head,
  output logic                 nonempty
);
  import gfne_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/gfne_back.sv
// Back end: owns the occupancy memory, walks the eight neighbours of a query and
// drives the result register. Depends on gfne_pkg and gfne_intf.
`default_nettype none

module gfne_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire gfne_pkg::cmd_t  cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_pop,
  input  wire gfne_pkg::cfg_t  cfg_regs,
  gfne_result_if.source        result
);
  import gfne_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;

  logic [7:0] mem [MAX_WIDTH * MAX_HEIGHT];

  logic [7:0] qx;
  logic [7:0] qy;
  logic [3:0] dir;

  // Stage holding the neighbour whose occupancy is being read.
  logic       s1_valid;
  logic       s1_inb;
  logic [7:0] s1_x;
  logic [7:0] s1_y;
  logic [7:0] rd_data;

  // The most recent free neighbour is held back until it is known whether
  // another one follows, which decides its last flag.
  logic       pend_valid;
  logic [7:0] pend_x;
  logic [7:0] pend_y;

  logic       o_valid;
  logic       o_found;
  logic [7:0] o_x;
  logic [7:0] o_y;
  logic       o_last;

  logic [8:0]        eff_w;
  logic [8:0]        eff_h;
  logic [9:0]        nx;
  logic [9:0]        ny;
  logic              inb;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              out_can;
  logic              s1_free;
  logic              s1_go;
  logic              issue;
  logic [1:0]        dx;
  logic [1:0]        dy;

  assign eff_w = (cfg_regs.grid_width  > EFF_W_MAX) ? EFF_W_MAX : cfg_regs.grid_width;
  assign eff_h = (cfg_regs.grid_height > EFF_H_MAX) ? EFF_H_MAX : cfg_regs.grid_height;

  assign dx  = dir_dx(dir[2:0]);
  assign dy  = dir_dy(dir[2:0]);
  assign nx  = {2'b00, qx} + {{8{dx[1]}}, dx};
  assign ny  = {2'b00, qy} + {{8{dy[1]}}, dy};
  assign inb = !nx[9] && !ny[9] && (nx[8:0] < eff_w) && (ny[8:0] < eff_h);

  assign raddr = ADDR_W'(ny[7:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx[7:0]);
  assign waddr = ADDR_W'(cmd.y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cmd.x);

  assign out_can = !o_valid || result.ready;
  assign s1_free = s1_inb && (rd_data < cfg_regs.free_threshold);
  assign s1_go   = s1_valid && (!s1_free || !pend_valid || out_can);
  assign issue   = (state == ST_SCAN) && !dir[3] && (!s1_valid || s1_go);
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  assign result.valid       = o_valid;
  assign result.found       = o_found;
  assign result.neighbour_x = o_x;
  assign result.neighbour_y = o_y;
  assign result.last        = o_last;

  // Single port: writes happen only while idle, reads only while scanning.
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.is_query) begin
      mem[waddr] <= cmd.occupancy;
    end else if (issue && inb) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_inb <= inb;
      s1_x   <= nx[7:0];
      s1_y   <= ny[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dir        <= '0;
      qx         <= '0;
      qy         <= '0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      pend_x     <= '0;
      pend_y     <= '0;
      o_valid    <= 1'b0;
      o_found    <= 1'b0;
      o_x        <= '0;
      o_y        <= '0;
      o_last     <= 1'b0;
    end else begin
      if (o_valid && result.ready) begin
        o_valid <= 1'b0;
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && s1_free) begin
        if (pend_valid) begin
          o_valid <= 1'b1;
          o_found <= 1'b1;
          o_x     <= pend_x;
          o_y     <= pend_y;
          o_last  <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_x     <= s1_x;
        pend_y     <= s1_y;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.is_query) begin
            qx         <= cmd.x;
            qy         <= cmd.y;
            dir        <= '0;
            pend_valid <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            dir <= dir + 1'b1;
          end
          if (dir[3] && (!s1_valid || s1_go)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_can) begin
            o_valid    <= 1'b1;
            o_found    <= pend_valid;
            o_x        <= pend_valid ? pend_x : 8'd0;
            o_y        <= pend_valid ? pend_y : 8'd0;
            o_last     <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
